[hw/rtl/tgro_pkg.sv]
// Shared types and constants for the tile grid rectangle overlap block.
package tgro_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int ROW_AW      = $clog2(MAX_ROWS);
    localparam int SPAN_W      = 7;
    localparam int DVD_W       = 17;
    localparam int CNT_W       = 5;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] CFG_TILE_PIXELS  = 2'd0;
    localparam logic [1:0] CFG_GRID_COLUMNS = 2'd1;
    localparam logic [1:0] CFG_GRID_ROWS    = 2'd2;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              value;
        logic              status;
        logic [SPAN_W-1:0] lo;
        logic [SPAN_W-1:0] hi;
        logic [SPAN_W-1:0] top;
        logic [SPAN_W-1:0] bottom;
    } cmd_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIV,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_IDLE,
        BE_WALK,
        BE_DONE
    } be_state_t;

endpackage

[hw/rtl/tile_grid_rect_overlap.sv]
// Top level of the tile grid rectangle overlap block.
// A fill or query walks one stored tile row per cycle over the rows it spans, and a
// query first passes through the front end's shared one-bit-per-cycle divider that
// turns its four pixel edges into tile indexes. The front end takes the next
// transaction while the back end is still walking rows, with a two-entry queue
// between them and a two-entry result queue at the output. The tile store is cleared
// at reset through per-row valid bits, so no clearing pass is needed.
module tile_grid_rect_overlap (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         operation,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [14:0]        extent_w,
    input  logic [14:0]        extent_h,
    input  logic               solid_value,
    output logic               empty,
    input  logic               pop,
    output logic               hit,
    output logic               status,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);
    import tgro_pkg::*;

    logic [8:0] tile_pixels_reg;
    logic [6:0] grid_columns_reg;
    logic [6:0] grid_rows_reg;
    cmd_t       fe_cmd, q_cmd;
    logic       fe_push, q_full, q_empty, be_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_pixels_reg  <= 9'd8;
            grid_columns_reg <= 7'd64;
            grid_rows_reg    <= 7'd64;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_TILE_PIXELS:  tile_pixels_reg  <= cfg_data;
                CFG_GRID_COLUMNS: grid_columns_reg <= cfg_data[6:0];
                CFG_GRID_ROWS:    grid_rows_reg    <= cfg_data[6:0];
                default:          tile_pixels_reg  <= tile_pixels_reg;
            endcase
        end
    end

    tgro_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .extent_w     (extent_w),
        .extent_h     (extent_h),
        .solid_value  (solid_value),
        .tile_pixels  (tile_pixels_reg),
        .grid_columns (grid_columns_reg),
        .grid_rows    (grid_rows_reg),
        .cmd          (fe_cmd),
        .cmd_push     (fe_push),
        .cmd_full     (q_full)
    );

    tgro_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_push),
        .wr_data (fe_cmd),
        .full    (q_full),
        .rd_en   (be_pop),
        .rd_data (q_cmd),
        .empty   (q_empty)
    );

    tgro_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (be_pop),
        .hit       (hit),
        .status    (status),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

[hw/rtl/tgro_front.sv]
// Front end: accepts transactions, classifies them and computes tile spans.
module tgro_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                operation,
    input  logic signed [15:0]        pos_x,
    input  logic signed [15:0]        pos_y,
    input  logic [14:0]               extent_w,
    input  logic [14:0]               extent_h,
    input  logic                      solid_value,
    input  logic [8:0]                tile_pixels,
    input  logic [6:0]                grid_columns,
    input  logic [6:0]                grid_rows,
    output tgro_pkg::cmd_t            cmd,
    output logic                      cmd_push,
    input  logic                      cmd_full
);
    import tgro_pkg::*;

    fe_state_t            state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic signed [15:0]   x_reg, y_reg;
    logic [14:0]          w_reg, h_reg;
    logic [1:0]           k_reg, k_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [8:0]           rem_reg, rem_next;

    logic [8:0]           ts;
    logic [SPAN_W-1:0]    cols, rows, lim;
    logic signed [17:0]   base, x1_in, y1_in;
    logic [DVD_W-1:0]     dvd_src, q_final;
    logic [9:0]           trial;
    logic                 qbit;
    logic [SPAN_W-1:0]    q_clamp;
    cmd_t                 in_cmd;

    function automatic logic [SPAN_W-1:0] clamp_span(input logic signed [17:0] v,
                                                     input logic [SPAN_W-1:0] lim_v);
        logic [SPAN_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({11'd0, lim_v}))
            r = lim_v;
        else
            r = v[SPAN_W-1:0];
        return r;
    endfunction

    assign ts   = (tile_pixels == 9'd0) ? 9'd1 : tile_pixels;
    assign cols = (grid_columns > SPAN_W'(MAX_COLUMNS)) ? SPAN_W'(MAX_COLUMNS) : grid_columns;
    assign rows = (grid_rows > SPAN_W'(MAX_ROWS)) ? SPAN_W'(MAX_ROWS) : grid_rows;
    assign lim  = k_reg[1] ? rows : cols;

    assign x1_in = 18'(pos_x) + $signed({3'd0, extent_w});
    assign y1_in = 18'(pos_y) + $signed({3'd0, extent_h});

    always_comb
    begin
        in_cmd = '0;
        in_cmd.kind  = CMD_NONE;
        in_cmd.value = solid_value;
        case (operation)
            OP_SET:
            begin
                if (pos_x >= 0 && pos_y >= 0 && pos_x < $signed({9'd0, cols})
                        && pos_y < $signed({9'd0, rows}))
                begin
                    in_cmd.kind   = CMD_WRITE;
                    in_cmd.lo     = pos_x[SPAN_W-1:0];
                    in_cmd.hi     = pos_x[SPAN_W-1:0] + SPAN_W'(1);
                    in_cmd.top    = pos_y[SPAN_W-1:0];
                    in_cmd.bottom = pos_y[SPAN_W-1:0] + SPAN_W'(1);
                end
                else
                begin
                    in_cmd.status = 1'b1;
                end
            end
            OP_FILL:
            begin
                if (extent_w != 15'd0 && extent_h != 15'd0)
                begin
                    in_cmd.kind   = CMD_WRITE;
                    in_cmd.status = pos_x < 0 || pos_y < 0
                                    || x1_in > $signed({11'd0, cols})
                                    || y1_in > $signed({11'd0, rows});
                    in_cmd.lo     = clamp_span(18'(pos_x), cols);
                    in_cmd.hi     = clamp_span(x1_in, cols);
                    in_cmd.top    = clamp_span(18'(pos_y), rows);
                    in_cmd.bottom = clamp_span(y1_in, rows);
                end
            end
            OP_QUERY:
            begin
                in_cmd.kind = CMD_QUERY;
            end
            default:
            begin
                in_cmd.kind = CMD_NONE;
            end
        endcase
    end

    always_comb
    begin
        case (k_reg)
            2'd0:    base = 18'(x_reg);
            2'd1:    base = 18'(x_reg) + $signed({3'd0, w_reg}) + $signed({9'd0, ts}) - 18'sd1;
            2'd2:    base = 18'(y_reg);
            default: base = 18'(y_reg) + $signed({3'd0, h_reg}) + $signed({9'd0, ts}) - 18'sd1;
        endcase
        // A negative edge clamps to zero whatever the quotient would be.
        if (base < 0 || (!k_reg[0] && base[17]))
            dvd_src = '0;
        else
            dvd_src = base[DVD_W-1:0];
        if ((k_reg == 2'd1 && 18'(x_reg) + $signed({3'd0, w_reg}) < 0)
                || (k_reg == 2'd3 && 18'(y_reg) + $signed({3'd0, h_reg}) < 0))
            dvd_src = '0;
    end

    always_comb
    begin
        logic [DVD_W-1:0] d;
        logic [8:0]       r;
        d = (cnt_reg == CNT_W'(DVD_W-1)) ? dvd_src : dvd_reg;
        r = (cnt_reg == CNT_W'(DVD_W-1)) ? 9'd0 : rem_reg;
        trial = {r, d[DVD_W-1]};
        qbit  = (trial >= {1'b0, ts});
        dvd_next = {d[DVD_W-2:0], 1'b0};
        rem_next = qbit ? 9'(trial - {1'b0, ts}) : trial[8:0];
        quo_next = {quo_reg[DVD_W-2:0], qbit};
    end

    assign q_final = quo_next;
    assign q_clamp = (q_final > DVD_W'(lim)) ? lim : q_final[SPAN_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        full       = 1'b1;
        cmd_push   = 1'b0;
        case (state_reg)
            FE_IDLE:
            begin
                full = 1'b0;
                if (push)
                begin
                    cmd_next = in_cmd;
                    k_next   = 2'd0;
                    cnt_next = CNT_W'(DVD_W-1);
                    state_next = (in_cmd.kind == CMD_QUERY) ? FE_DIV : FE_PUSH;
                end
            end
            FE_DIV:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    case (k_reg)
                        2'd0:    cmd_next.lo     = q_clamp;
                        2'd1:    cmd_next.hi     = q_clamp;
                        2'd2:    cmd_next.top    = q_clamp;
                        default: cmd_next.bottom = q_clamp;
                    endcase
                    cnt_next = CNT_W'(DVD_W-1);
                    k_next   = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                        state_next = FE_PUSH;
                end
            end
            FE_PUSH:
            begin
                if (!cmd_full)
                begin
                    cmd_push   = 1'b1;
                    state_next = FE_IDLE;
                end
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

    assign cmd = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FE_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (state_reg == FE_IDLE && push)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
            w_reg <= extent_w;
            h_reg <= extent_h;
        end
    end

`ifndef SYNTHESIS
    a_push_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> state_reg == FE_PUSH) else $error("command pushed outside push state");
    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != FE_IDLE) |-> full) else $error("front accepts while busy");
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FE_DIV) |-> cnt_reg <= CNT_W'(DVD_W-1)) else $error("divider count out of range");
`endif

endmodule

[hw/rtl/tgro_cmd_queue.sv]
// Two-entry command queue between the front end and the back end.
module tgro_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  tgro_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output tgro_pkg::cmd_t rd_data,
    output logic           empty
);
    import tgro_pkg::*;

    cmd_t       entry_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = entry_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg + 2'(wr_en && !full) - 2'(rd_en && !empty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en && !full)
                wptr_reg <= !wptr_reg;
            if (rd_en && !empty)
                rptr_reg <= !rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
            entry_reg[wptr_reg] <= wr_data;
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2) else $error("command queue count overflow");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wptr_reg == rptr_reg)
        else $error("command queue pointers inconsistent");
    a_ptr_diff: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> wptr_reg != rptr_reg)
        else $error("command queue pointers inconsistent");
`endif

endmodule

[hw/rtl/tgro_back.sv]
// Back end: walks tile rows for writes and queries and queues the results.
module tgro_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tgro_pkg::cmd_t cmd,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    output logic           hit,
    output logic           status,
    output logic           empty,
    input  logic           pop
);
    import tgro_pkg::*;

    be_state_t                 state_reg, state_next;
    logic [MAX_COLUMNS-1:0]    mem [MAX_ROWS];
    logic [MAX_ROWS-1:0]       valid_reg;
    logic [MAX_COLUMNS-1:0]    rd_reg;
    logic                      rd_valid_reg;
    logic [MAX_COLUMNS-1:0]    mask_reg, mask_next;
    logic [SPAN_W-1:0]         row_reg, row_next, end_reg, end_next;
    logic [ROW_AW-1:0]         pend_row_reg;
    logic                      pend_reg, pend_next;
    logic                      is_write_reg, is_write_next;
    logic                      value_reg, value_next;
    logic                      hit_reg, hit_next;
    logic                      status_reg, status_next;
    logic                      issue;
    logic [MAX_COLUMNS-1:0]    row_data, upper, lower;
    logic                      res_push, res_full;
    logic [1:0]                res_entry_reg [2];
    logic                      res_wptr_reg, res_rptr_reg;
    logic [1:0]                res_count_reg;

    assign res_full = (res_count_reg == 2'd2);
    assign empty    = (res_count_reg == 2'd0);
    assign hit      = res_entry_reg[res_rptr_reg][1];
    assign status   = res_entry_reg[res_rptr_reg][0];

    assign upper    = (cmd.hi >= SPAN_W'(MAX_COLUMNS)) ? '1
                      : (MAX_COLUMNS'(1) << cmd.hi) - MAX_COLUMNS'(1);
    assign lower    = (MAX_COLUMNS'(1) << cmd.lo) - MAX_COLUMNS'(1);
    assign row_data = rd_valid_reg ? rd_reg : '0;
    assign issue    = (state_reg == BE_WALK) && (row_reg < end_reg);

    always_comb
    begin
        state_next    = state_reg;
        mask_next     = mask_reg;
        row_next      = row_reg;
        end_next      = end_reg;
        is_write_next = is_write_reg;
        value_next    = value_reg;
        hit_next      = hit_reg;
        status_next   = status_reg;
        pend_next     = issue;
        cmd_pop       = 1'b0;
        res_push      = 1'b0;
        case (state_reg)
            BE_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop       = 1'b1;
                    mask_next     = upper & ~lower;
                    row_next      = cmd.top;
                    end_next      = (cmd.lo < cmd.hi) ? cmd.bottom : cmd.top;
                    is_write_next = (cmd.kind == CMD_WRITE);
                    value_next    = cmd.value;
                    hit_next      = 1'b0;
                    status_next   = cmd.status;
                    state_next    = (cmd.kind == CMD_NONE) ? BE_DONE : BE_WALK;
                end
            end
            BE_WALK:
            begin
                if (issue)
                    row_next = row_reg + SPAN_W'(1);
                if (pend_reg && !is_write_reg && (row_data & mask_reg) != '0)
                    hit_next = 1'b1;
                if (!issue && !pend_reg)
                    state_next = BE_DONE;
            end
            BE_DONE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = BE_IDLE;
                end
            end
            default:
            begin
                state_next = BE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BE_IDLE;
            valid_reg     <= '0;
            pend_reg      <= 1'b0;
            res_wptr_reg  <= 1'b0;
            res_rptr_reg  <= 1'b0;
            res_count_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (pend_reg && is_write_reg)
                valid_reg[pend_row_reg] <= 1'b1;
            res_count_reg <= res_count_reg + 2'(res_push) - 2'(pop && !empty);
            if (res_push)
                res_wptr_reg <= !res_wptr_reg;
            if (pop && !empty)
                res_rptr_reg <= !res_rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg     <= mask_next;
        row_reg      <= row_next;
        end_reg      <= end_next;
        is_write_reg <= is_write_next;
        value_reg    <= value_next;
        hit_reg      <= hit_next;
        status_reg   <= status_next;
        if (issue)
        begin
            rd_reg       <= mem[row_reg[ROW_AW-1:0]];
            rd_valid_reg <= valid_reg[row_reg[ROW_AW-1:0]];
            pend_row_reg <= row_reg[ROW_AW-1:0];
        end
        if (pend_reg && is_write_reg)
            mem[pend_row_reg] <= value_reg ? (row_data | mask_reg) : (row_data & ~mask_reg);
        if (res_push)
            res_entry_reg[res_wptr_reg] <= {hit_reg & !is_write_reg, status_reg};
    end

`ifndef SYNTHESIS
    a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_count_reg <= 2'd2) else $error("result queue count overflow");
    a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == BE_WALK) else $error("row pending outside walk");
    a_push_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> state_reg == BE_IDLE) else $error("result pushed without finishing");
`endif

endmodule
